### rtl/dnsmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser package
// Section and field codes, parse state and per-byte result types.
// ----------------------------------------------------------------------------
package dnsmp_pkg;

   localparam logic [2:0] SEC_HEADER     = 3'd0;
   localparam logic [2:0] SEC_QUESTION   = 3'd1;
   localparam logic [2:0] SEC_ANSWER     = 3'd2;
   localparam logic [2:0] SEC_AUTHORITY  = 3'd3;
   localparam logic [2:0] SEC_ADDITIONAL = 3'd4;
   localparam logic [2:0] SEC_TRAILING   = 3'd5;

   localparam logic [3:0] FK_ID       = 4'd0;
   localparam logic [3:0] FK_FLAGS    = 4'd1;
   localparam logic [3:0] FK_QDCOUNT  = 4'd2;
   localparam logic [3:0] FK_ANCOUNT  = 4'd3;
   localparam logic [3:0] FK_NSCOUNT  = 4'd4;
   localparam logic [3:0] FK_ARCOUNT  = 4'd5;
   localparam logic [3:0] FK_NAME     = 4'd6;
   localparam logic [3:0] FK_NAME_END = 4'd7;
   localparam logic [3:0] FK_POINTER  = 4'd8;
   localparam logic [3:0] FK_TYPE     = 4'd9;
   localparam logic [3:0] FK_CLASS    = 4'd10;
   localparam logic [3:0] FK_TTL      = 4'd11;
   localparam logic [3:0] FK_RDLEN    = 4'd12;
   localparam logic [3:0] FK_RDATA    = 4'd13;
   localparam logic [3:0] FK_EXTRA    = 4'd14;

   typedef struct packed {
      logic [2:0]  section;
      logic [3:0]  field;
      logic [1:0]  byte_in_field;
      logic [23:0] accum;
      logic [15:0] qd_count;
      logic [15:0] an_count;
      logic [15:0] ns_count;
      logic [15:0] ar_count;
      logic [15:0] entry_index;
      logic [15:0] rdata_left;
      logic        name_first;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      section:       SEC_HEADER,
      field:         FK_ID,
      byte_in_field: 2'd0,
      accum:         24'd0,
      qd_count:      16'd0,
      an_count:      16'd0,
      ns_count:      16'd0,
      ar_count:      16'd0,
      entry_index:   16'd0,
      rdata_left:    16'd0,
      name_first:    1'b1
   };

   typedef struct packed {
      logic [2:0]  section;
      logic [3:0]  field_kind;
      logic [31:0] field_value;
      logic        field_done;
      logic [15:0] record_number;
      logic        qr_bit;
      logic [3:0]  opcode_bits;
      logic [3:0]  aa_tc_rd_ra;
      logic [2:0]  reserved_bits;
      logic [3:0]  rcode_bits;
   } step_result_type;

endpackage

### rtl/dnsmp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser input channel
// Valid/ready channel carrying one message byte per transaction.
// ----------------------------------------------------------------------------
interface dnsmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       msg_start;

   modport source (output valid, output data_byte, output msg_start, input ready);
   modport sink   (input valid, input data_byte, input msg_start, output ready);
endinterface

### rtl/dnsmp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser result channel
// Valid/ready channel carrying the tags of one byte per transaction.
// ----------------------------------------------------------------------------
interface dnsmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  section;
   logic [3:0]  field_kind;
   logic [31:0] field_value;
   logic        field_done;
   logic [15:0] record_number;
   logic        qr_bit;
   logic [3:0]  opcode_bits;
   logic [3:0]  aa_tc_rd_ra;
   logic [2:0]  reserved_bits;
   logic [3:0]  rcode_bits;

   modport source (
      output valid, output section, output field_kind, output field_value,
      output field_done, output record_number, output qr_bit, output opcode_bits,
      output aa_tc_rd_ra, output reserved_bits, output rcode_bits, input ready
   );
   modport sink (
      input valid, input section, input field_kind, input field_value,
      input field_done, input record_number, input qr_bit, input opcode_bits,
      input aa_tc_rd_ra, input reserved_bits, input rcode_bits, output ready
   );
endinterface

### rtl/dnsmp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser step logic
// Tags one byte from the current parse state and computes the next state.
// ----------------------------------------------------------------------------
module dnsmp_step (
   input  dnsmp_pkg::parse_state_type state_cur,
   input  logic [7:0]                 data_byte,
   input  logic                       msg_start,
   output dnsmp_pkg::parse_state_type state_nxt,
   output dnsmp_pkg::step_result_type result
);

   function automatic logic [15:0] count_of(input dnsmp_pkg::parse_state_type st,
                                            input logic [2:0] sec);
      logic [15:0] c;
      unique case (sec)
         dnsmp_pkg::SEC_QUESTION:   c = st.qd_count;
         dnsmp_pkg::SEC_ANSWER:     c = st.an_count;
         dnsmp_pkg::SEC_AUTHORITY:  c = st.ns_count;
         dnsmp_pkg::SEC_ADDITIONAL: c = st.ar_count;
         default:                   c = 16'd0;
      endcase
      return c;
   endfunction

   function automatic dnsmp_pkg::parse_state_type enter_after(
      input dnsmp_pkg::parse_state_type st, input logic [2:0] from);
      dnsmp_pkg::parse_state_type o;
      logic [2:0] sec;
      o = st;
      o.entry_index   = 16'd0;
      o.byte_in_field = 2'd0;
      o.accum         = 24'd0;
      o.name_first    = 1'b1;
      if (from < dnsmp_pkg::SEC_QUESTION && st.qd_count != 16'd0)
         sec = dnsmp_pkg::SEC_QUESTION;
      else if (from < dnsmp_pkg::SEC_ANSWER && st.an_count != 16'd0)
         sec = dnsmp_pkg::SEC_ANSWER;
      else if (from < dnsmp_pkg::SEC_AUTHORITY && st.ns_count != 16'd0)
         sec = dnsmp_pkg::SEC_AUTHORITY;
      else if (from < dnsmp_pkg::SEC_ADDITIONAL && st.ar_count != 16'd0)
         sec = dnsmp_pkg::SEC_ADDITIONAL;
      else
         sec = dnsmp_pkg::SEC_TRAILING;
      o.section = sec;
      o.field   = (sec == dnsmp_pkg::SEC_TRAILING) ? dnsmp_pkg::FK_EXTRA
                                                   : dnsmp_pkg::FK_NAME;
      return o;
   endfunction

   function automatic dnsmp_pkg::parse_state_type end_entry(
      input dnsmp_pkg::parse_state_type st);
      dnsmp_pkg::parse_state_type o;
      logic [16:0] nxt_idx;
      nxt_idx = {1'b0, st.entry_index} + 17'd1;
      if (nxt_idx >= {1'b0, count_of(st, st.section)}) begin
         o = enter_after(st, st.section);
      end else begin
         o = st;
         o.entry_index   = nxt_idx[15:0];
         o.field         = dnsmp_pkg::FK_NAME;
         o.name_first    = 1'b1;
         o.byte_in_field = 2'd0;
         o.accum         = 24'd0;
      end
      return o;
   endfunction

   dnsmp_pkg::parse_state_type s;
   dnsmp_pkg::parse_state_type n;
   dnsmp_pkg::step_result_type r;
   logic [15:0] word16;
   logic [31:0] word32;
   logic [2:0]  bif_p1;
   logic [2:0]  fld_len;

   always_comb begin
      s = msg_start ? dnsmp_pkg::PARSE_RESET : state_cur;
      n = s;
      word16  = {s.accum[7:0], data_byte};
      word32  = {s.accum, data_byte};
      bif_p1  = {1'b0, s.byte_in_field} + 3'd1;
      fld_len = (s.field == dnsmp_pkg::FK_TTL) ? 3'd4 : 3'd2;

      r.section       = s.section;
      r.field_kind    = s.field;
      r.field_value   = {24'd0, data_byte};
      r.field_done    = 1'b0;
      r.record_number = s.entry_index;
      r.qr_bit        = 1'b0;
      r.opcode_bits   = 4'd0;
      r.aa_tc_rd_ra   = 4'd0;
      r.reserved_bits = 3'd0;
      r.rcode_bits    = 4'd0;

      if (s.section == dnsmp_pkg::SEC_HEADER) begin
         r.record_number = 16'd0;
         if (s.field > dnsmp_pkg::FK_ARCOUNT) begin
            n.field      = dnsmp_pkg::FK_ID;
            r.field_kind = dnsmp_pkg::FK_ID;
         end
         if (s.byte_in_field == 2'd0) begin
            n.accum         = {16'd0, data_byte};
            n.byte_in_field = 2'd1;
         end else begin
            r.field_done  = 1'b1;
            r.field_value = {16'd0, word16};
            case (n.field)
               dnsmp_pkg::FK_FLAGS: begin
                  r.qr_bit        = word16[15];
                  r.opcode_bits   = word16[14:11];
                  r.aa_tc_rd_ra   = word16[10:7];
                  r.reserved_bits = word16[6:4];
                  r.rcode_bits    = word16[3:0];
               end
               dnsmp_pkg::FK_QDCOUNT: n.qd_count = word16;
               dnsmp_pkg::FK_ANCOUNT: n.an_count = word16;
               dnsmp_pkg::FK_NSCOUNT: n.ns_count = word16;
               dnsmp_pkg::FK_ARCOUNT: n.ar_count = word16;
               default: ;
            endcase
            n.byte_in_field = 2'd0;
            n.accum         = 24'd0;
            if (n.field == dnsmp_pkg::FK_ARCOUNT)
               n = enter_after(n, dnsmp_pkg::SEC_HEADER);
            else
               n.field = n.field + 4'd1;
         end
      end else if (s.section >= dnsmp_pkg::SEC_QUESTION &&
                   s.section <= dnsmp_pkg::SEC_ADDITIONAL) begin
         case (s.field) inside
            dnsmp_pkg::FK_NAME: begin
               if (s.section > dnsmp_pkg::SEC_QUESTION && s.name_first &&
                   data_byte[7:6] == 2'b11) begin
                  r.field_kind    = dnsmp_pkg::FK_POINTER;
                  n.field         = dnsmp_pkg::FK_POINTER;
                  n.accum         = {16'd0, data_byte};
                  n.byte_in_field = 2'd1;
                  n.name_first    = 1'b0;
               end else if (data_byte == 8'd0) begin
                  r.field_kind    = dnsmp_pkg::FK_NAME_END;
                  r.field_value   = 32'd0;
                  r.field_done    = 1'b1;
                  n.field         = dnsmp_pkg::FK_TYPE;
                  n.byte_in_field = 2'd0;
                  n.accum         = 24'd0;
                  n.name_first    = 1'b1;
               end else begin
                  n.name_first = 1'b0;
               end
            end
            dnsmp_pkg::FK_POINTER: begin
               r.field_value   = {16'd0, word16};
               r.field_done    = 1'b1;
               n.field         = dnsmp_pkg::FK_TYPE;
               n.byte_in_field = 2'd0;
               n.accum         = 24'd0;
               n.name_first    = 1'b1;
            end
            dnsmp_pkg::FK_TYPE, dnsmp_pkg::FK_CLASS,
            dnsmp_pkg::FK_TTL, dnsmp_pkg::FK_RDLEN: begin
               if (bif_p1 >= fld_len) begin
                  r.field_done    = 1'b1;
                  r.field_value   = word32;
                  n.byte_in_field = 2'd0;
                  n.accum         = 24'd0;
                  case (s.field)
                     dnsmp_pkg::FK_TYPE: n.field = dnsmp_pkg::FK_CLASS;
                     dnsmp_pkg::FK_CLASS: begin
                        if (s.section == dnsmp_pkg::SEC_QUESTION)
                           n = end_entry(n);
                        else
                           n.field = dnsmp_pkg::FK_TTL;
                     end
                     dnsmp_pkg::FK_TTL: n.field = dnsmp_pkg::FK_RDLEN;
                     default: begin
                        n.rdata_left = word32[15:0];
                        if (word32[15:0] == 16'd0)
                           n = end_entry(n);
                        else
                           n.field = dnsmp_pkg::FK_RDATA;
                     end
                  endcase
               end else begin
                  n.accum         = word32[23:0];
                  n.byte_in_field = bif_p1[1:0];
               end
            end
            dnsmp_pkg::FK_RDATA: begin
               if (s.rdata_left <= 16'd1) begin
                  n.rdata_left = 16'd0;
                  r.field_done = 1'b1;
                  n = end_entry(n);
               end else begin
                  n.rdata_left = s.rdata_left - 16'd1;
               end
            end
            default: begin
               r.field_kind    = dnsmp_pkg::FK_EXTRA;
               r.section       = dnsmp_pkg::SEC_TRAILING;
               r.record_number = 16'd0;
               n.section       = dnsmp_pkg::SEC_TRAILING;
               n.field         = dnsmp_pkg::FK_EXTRA;
            end
         endcase
      end else begin
         r.section       = dnsmp_pkg::SEC_TRAILING;
         r.field_kind    = dnsmp_pkg::FK_EXTRA;
         r.record_number = 16'd0;
         n.section       = dnsmp_pkg::SEC_TRAILING;
         n.field         = dnsmp_pkg::FK_EXTRA;
      end
   end

   assign state_nxt = n;
   assign result    = r;

endmodule

### rtl/dns_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser
// A byte transaction passes the input register, then the result register.
// Throughput: one byte per cycle unless the result channel stalls, limited by
// the combinational parse step that updates the parse state. Synchronous
// active-high reset clears both valid flags and restarts at header id byte 0.
// ----------------------------------------------------------------------------
module dns_message_parser (
   input  logic        clock,
   input  logic        reset,
   dnsmp_req_if.sink   req_chan,
   dnsmp_rsp_if.source rsp_chan
);

   logic                       in_valid_ff;
   logic [7:0]                 in_byte_ff;
   logic                       in_start_ff;
   logic                       out_valid_ff;
   dnsmp_pkg::step_result_type out_res_ff;
   dnsmp_pkg::parse_state_type state_ff;
   dnsmp_pkg::parse_state_type state_in;
   dnsmp_pkg::step_result_type step_res;
   logic                       advance;
   logic                       in_ready;

   dnsmp_step u_step (
      .state_cur (state_ff),
      .data_byte (in_byte_ff),
      .msg_start (in_start_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign in_ready = !in_valid_ff || advance;
   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= dnsmp_pkg::PARSE_RESET;
      end else begin
         if (in_ready)
            in_valid_ff <= req_chan.valid;
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && in_ready) begin
         in_byte_ff  <= req_chan.data_byte;
         in_start_ff <= req_chan.msg_start;
      end
      if (advance)
         out_res_ff <= step_res;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.section       = out_res_ff.section;
   assign rsp_chan.field_kind    = out_res_ff.field_kind;
   assign rsp_chan.field_value   = out_res_ff.field_value;
   assign rsp_chan.field_done    = out_res_ff.field_done;
   assign rsp_chan.record_number = out_res_ff.record_number;
   assign rsp_chan.qr_bit        = out_res_ff.qr_bit;
   assign rsp_chan.opcode_bits   = out_res_ff.opcode_bits;
   assign rsp_chan.aa_tc_rd_ra   = out_res_ff.aa_tc_rd_ra;
   assign rsp_chan.reserved_bits = out_res_ff.reserved_bits;
   assign rsp_chan.rcode_bits    = out_res_ff.rcode_bits;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser testbench
// Streams DNS messages into the parser one byte per transaction: a short
// directed table, then random well-formed, truncated and noise messages.
// Each result is checked field by field against table tags or a byte tagger
// model kept in step with the input, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BYTES   = 1750;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT_BYTE   = 400;
   localparam int HOLD_CYCLES    = 300;
   localparam int MSG_CAP        = 256;

   typedef struct {
      logic [7:0]                 data;
      logic                       start;
      bit                         typed;
      dnsmp_pkg::step_result_type tags;
   } stim_row_type;

   logic clock;
   logic reset;

   dnsmp_req_if req_bus ();
   dnsmp_rsp_if rsp_bus ();

   dns_message_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // tagger model state
   logic [2:0]  seg;
   logic [3:0]  fld;
   logic [1:0]  nbyte;
   logic [31:0] acc;
   logic [15:0] qd_n, an_n, ns_n, ar_n;
   logic [15:0] entry;
   logic [15:0] rd_left;
   logic        at_name_start;

   dnsmp_pkg::step_result_type expected_tags[$];
   stim_row_type               dir_rows[$];
   logic [8:0]                 msg_bytes[$];

   bit  calm;
   bit  hold_pending;
   int  bytes_sent;
   int  results_seen;
   int  errors;
   int  idle_cycles;
   int  msg_count;
   int  broken_count;
   dnsmp_pkg::step_result_type got;
   dnsmp_pkg::step_result_type want;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic void clear_parser();
      seg           = dnsmp_pkg::SEC_HEADER;
      fld           = dnsmp_pkg::FK_ID;
      nbyte         = 2'd0;
      acc           = 32'd0;
      qd_n          = 16'd0;
      an_n          = 16'd0;
      ns_n          = 16'd0;
      ar_n          = 16'd0;
      entry         = 16'd0;
      rd_left       = 16'd0;
      at_name_start = 1'b1;
   endfunction

   function automatic logic [15:0] count_in(logic [2:0] s);
      case (s)
         dnsmp_pkg::SEC_QUESTION:   return qd_n;
         dnsmp_pkg::SEC_ANSWER:     return an_n;
         dnsmp_pkg::SEC_AUTHORITY:  return ns_n;
         dnsmp_pkg::SEC_ADDITIONAL: return ar_n;
         default:                   return 16'd0;
      endcase
   endfunction

   // move to the first non-empty section after 'from', or to trailing
   function automatic void skip_from(logic [2:0] from);
      int s;
      entry         = 16'd0;
      nbyte         = 2'd0;
      acc           = 32'd0;
      at_name_start = 1'b1;
      for (s = int'(from) + 1; s <= int'(dnsmp_pkg::SEC_ADDITIONAL); s++) begin
         if (count_in(3'(s)) != 16'd0) begin
            seg = 3'(s);
            fld = dnsmp_pkg::FK_NAME;
            return;
         end
      end
      seg = dnsmp_pkg::SEC_TRAILING;
      fld = dnsmp_pkg::FK_EXTRA;
   endfunction

   function automatic void finish_entry();
      if ({16'd0, entry} + 32'd1 >= {16'd0, count_in(seg)}) begin
         skip_from(seg);
      end else begin
         entry         = entry + 16'd1;
         fld           = dnsmp_pkg::FK_NAME;
         at_name_start = 1'b1;
         nbyte         = 2'd0;
         acc           = 32'd0;
      end
   endfunction

   function automatic dnsmp_pkg::step_result_type tag_byte(logic [7:0] b, logic start);
      dnsmp_pkg::step_result_type r;
      logic [15:0]                w;
      int                         len;
      if (start) clear_parser();
      r               = '0;
      r.section       = seg;
      r.field_kind    = fld;
      r.field_value   = {24'd0, b};
      r.record_number = entry;
      if (seg == dnsmp_pkg::SEC_HEADER) begin
         r.record_number = 16'd0;
         if (fld > dnsmp_pkg::FK_ARCOUNT) begin
            fld          = dnsmp_pkg::FK_ID;
            r.field_kind = dnsmp_pkg::FK_ID;
         end
         if (nbyte == 2'd0) begin
            acc   = {24'd0, b};
            nbyte = 2'd1;
         end else begin
            w             = {acc[7:0], b};
            r.field_done  = 1'b1;
            r.field_value = {16'd0, w};
            case (fld)
               dnsmp_pkg::FK_FLAGS: begin
                  r.qr_bit        = w[15];
                  r.opcode_bits   = w[14:11];
                  r.aa_tc_rd_ra   = w[10:7];
                  r.reserved_bits = w[6:4];
                  r.rcode_bits    = w[3:0];
               end
               dnsmp_pkg::FK_QDCOUNT: qd_n = w;
               dnsmp_pkg::FK_ANCOUNT: an_n = w;
               dnsmp_pkg::FK_NSCOUNT: ns_n = w;
               dnsmp_pkg::FK_ARCOUNT: ar_n = w;
               default: ;
            endcase
            nbyte = 2'd0;
            acc   = 32'd0;
            if (fld == dnsmp_pkg::FK_ARCOUNT) skip_from(dnsmp_pkg::SEC_HEADER);
            else fld = fld + 4'd1;
         end
      end else if (seg >= dnsmp_pkg::SEC_QUESTION && seg <= dnsmp_pkg::SEC_ADDITIONAL) begin
         case (fld) inside
            dnsmp_pkg::FK_NAME: begin
               if (seg > dnsmp_pkg::SEC_QUESTION && at_name_start && b[7:6] == 2'b11) begin
                  r.field_kind  = dnsmp_pkg::FK_POINTER;
                  fld           = dnsmp_pkg::FK_POINTER;
                  acc           = {24'd0, b};
                  nbyte         = 2'd1;
                  at_name_start = 1'b0;
               end else if (b == 8'd0) begin
                  r.field_kind  = dnsmp_pkg::FK_NAME_END;
                  r.field_value = 32'd0;
                  r.field_done  = 1'b1;
                  fld           = dnsmp_pkg::FK_TYPE;
                  nbyte         = 2'd0;
                  acc           = 32'd0;
                  at_name_start = 1'b1;
               end else begin
                  at_name_start = 1'b0;
               end
            end
            dnsmp_pkg::FK_POINTER: begin
               r.field_value = {16'd0, acc[7:0], b};
               r.field_done  = 1'b1;
               fld           = dnsmp_pkg::FK_TYPE;
               nbyte         = 2'd0;
               acc           = 32'd0;
               at_name_start = 1'b1;
            end
            dnsmp_pkg::FK_TYPE, dnsmp_pkg::FK_CLASS,
            dnsmp_pkg::FK_TTL, dnsmp_pkg::FK_RDLEN: begin
               len = (fld == dnsmp_pkg::FK_TTL) ? 4 : 2;
               acc = {acc[23:0], b};
               if (int'(nbyte) + 1 >= len) begin
                  r.field_done  = 1'b1;
                  r.field_value = acc;
                  nbyte         = 2'd0;
                  acc           = 32'd0;
                  case (fld)
                     dnsmp_pkg::FK_TYPE:  fld = dnsmp_pkg::FK_CLASS;
                     dnsmp_pkg::FK_CLASS: begin
                        if (seg == dnsmp_pkg::SEC_QUESTION) finish_entry();
                        else fld = dnsmp_pkg::FK_TTL;
                     end
                     dnsmp_pkg::FK_TTL:   fld = dnsmp_pkg::FK_RDLEN;
                     default: begin
                        rd_left = r.field_value[15:0];
                        if (rd_left == 16'd0) finish_entry();
                        else fld = dnsmp_pkg::FK_RDATA;
                     end
                  endcase
               end else begin
                  nbyte = nbyte + 2'd1;
               end
            end
            dnsmp_pkg::FK_RDATA: begin
               if (rd_left <= 16'd1) begin
                  rd_left      = 16'd0;
                  r.field_done = 1'b1;
                  finish_entry();
               end else begin
                  rd_left = rd_left - 16'd1;
               end
            end
            default: begin
               r.field_kind    = dnsmp_pkg::FK_EXTRA;
               r.section       = dnsmp_pkg::SEC_TRAILING;
               r.record_number = 16'd0;
               seg             = dnsmp_pkg::SEC_TRAILING;
               fld             = dnsmp_pkg::FK_EXTRA;
            end
         endcase
      end else begin
         r.section       = dnsmp_pkg::SEC_TRAILING;
         r.field_kind    = dnsmp_pkg::FK_EXTRA;
         r.record_number = 16'd0;
         seg             = dnsmp_pkg::SEC_TRAILING;
         fld             = dnsmp_pkg::FK_EXTRA;
      end
      return r;
   endfunction

   // flg packs qr, opcode, aa/tc/rd/ra, reserved, rcode from msb down
   function automatic void add_row(logic [7:0] b, int s, int chk, logic [2:0] sec,
                                   logic [3:0] kind, logic [31:0] val, int done,
                                   logic [15:0] flg);
      stim_row_type row;
      row.data                 = b;
      row.start                = (s != 0);
      row.typed                = (chk != 0);
      row.tags                 = '0;
      row.tags.section         = sec;
      row.tags.field_kind      = kind;
      row.tags.field_value     = val;
      row.tags.field_done      = (done != 0);
      row.tags.qr_bit          = flg[15];
      row.tags.opcode_bits     = flg[14:11];
      row.tags.aa_tc_rd_ra     = flg[10:7];
      row.tags.reserved_bits   = flg[6:4];
      row.tags.rcode_bits      = flg[3:0];
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void put_byte(logic [8:0] v);
      msg_bytes.insert(msg_bytes.size(), v);
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_count(int hi);
      if ($urandom_range(0, 24) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, hi));
   endfunction

   task automatic push16(logic [15:0] v);
      put_byte({1'b0, v[15:8]});
      put_byte({1'b0, v[7:0]});
   endtask

   task automatic push_name(bit in_record);
      int n, i;
      if (in_record && $urandom_range(0, 2) == 0) begin
         put_byte({1'b0, 2'b11, 6'($urandom)});
         put_byte({1'b0, 8'($urandom)});
         return;
      end
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) begin
         if (i == 0 && in_record) put_byte({1'b0, 8'($urandom_range(1, 191))});
         else put_byte({1'b0, 8'($urandom_range(1, 255))});
      end
      put_byte(9'h000);
   endtask

   task automatic build_message();
      int          qd, an, ns, ar, n, i, k, r, cut;
      logic [15:0] rdlen;
      msg_bytes.delete();
      msg_count++;
      if ($urandom_range(0, 11) == 0) begin
         broken_count++;
         n = $urandom_range(1, 30);
         for (i = 0; i < n; i++)
            put_byte({(i == 0 || $urandom_range(0, 19) == 0), 8'($urandom)});
         return;
      end
      qd = int'(pick_count(3));
      an = int'(pick_count(3));
      ns = int'(pick_count(2));
      ar = int'(pick_count(2));
      push16(16'($urandom));
      push16(16'($urandom));
      push16(16'(qd));
      push16(16'(an));
      push16(16'(ns));
      push16(16'(ar));
      for (i = 0; i < qd && msg_bytes.size() < MSG_CAP; i++) begin
         push_name(1'b0);
         push16(16'($urandom));
         push16(16'($urandom));
      end
      n = an + ns + ar;
      for (i = 0; i < n && msg_bytes.size() < MSG_CAP; i++) begin
         push_name(1'b1);
         push16(16'($urandom));
         push16(16'($urandom));
         push16(16'($urandom));
         push16(16'($urandom));
         r = $urandom_range(0, 29);
         if (r < 6) rdlen = 16'd0;
         else if (r == 29) rdlen = 16'($urandom);
         else rdlen = 16'($urandom_range(1, 8));
         push16(rdlen);
         for (k = 0; k < int'(rdlen) && msg_bytes.size() < MSG_CAP; k++)
            put_byte({1'b0, 8'($urandom)});
      end
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) put_byte({1'b0, 8'($urandom)});
      msg_bytes[0][8] = ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 7) == 0) begin
         broken_count++;
         cut = $urandom_range(1, msg_bytes.size());
         while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
   endtask

   task automatic send_byte(logic [7:0] b, logic s, bit chk,
                            dnsmp_pkg::step_result_type typed_tags);
      int                         gap;
      dnsmp_pkg::step_result_type pred;
      pred = tag_byte(b, s);
      expected_tags.insert(expected_tags.size(), chk ? typed_tags : pred);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.msg_start <= s;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      if (bytes_sent == HOLD_AT_BYTE) hold_pending = 1'b1;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: result %0d %s mismatch, expected %0h actual %0h",
                  $time, results_seen, name, exp_v, act_v);
      end
   endtask

   // receiver: random stalls plus one long hold-off
   initial begin : receiver
      int stall_left;
      int g;
      stall_left   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left = g - 1;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.section       = rsp_bus.section;
            got.field_kind    = rsp_bus.field_kind;
            got.field_value   = rsp_bus.field_value;
            got.field_done    = rsp_bus.field_done;
            got.record_number = rsp_bus.record_number;
            got.qr_bit        = rsp_bus.qr_bit;
            got.opcode_bits   = rsp_bus.opcode_bits;
            got.aa_tc_rd_ra   = rsp_bus.aa_tc_rd_ra;
            got.reserved_bits = rsp_bus.reserved_bits;
            got.rcode_bits    = rsp_bus.rcode_bits;
            if (expected_tags.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transaction, expected none actual %0h",
                        $time, got);
            end else begin
               want = expected_tags.pop_front();
               check_field("section", 32'(want.section), 32'(got.section));
               check_field("field_kind", 32'(want.field_kind), 32'(got.field_kind));
               check_field("field_value", want.field_value, got.field_value);
               check_field("field_done", 32'(want.field_done), 32'(got.field_done));
               check_field("record_number", 32'(want.record_number),
                           32'(got.record_number));
               check_field("qr_bit", 32'(want.qr_bit), 32'(got.qr_bit));
               check_field("opcode_bits", 32'(want.opcode_bits), 32'(got.opcode_bits));
               check_field("aa_tc_rd_ra", 32'(want.aa_tc_rd_ra), 32'(got.aa_tc_rd_ra));
               check_field("reserved_bits", 32'(want.reserved_bits),
                           32'(got.reserved_bits));
               check_field("rcode_bits", 32'(want.rcode_bits), 32'(got.rcode_bits));
            end
            results_seen++;
         end
      end
   end

   initial begin : stimulus
      int i;
      int dir_len;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'd0;
      req_bus.msg_start <= 1'b0;
      reset             <= 1'b1;
      calm              = 1'b0;
      hold_pending      = 1'b0;
      bytes_sent        = 0;
      results_seen      = 0;
      errors            = 0;
      idle_cycles       = 0;
      msg_count         = 0;
      broken_count      = 0;
      clear_parser();

      // first message right after reset, no start flag: all-ones id and flags,
      // one answer with a compression pointer and zero rdlength, then trailing
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ID, 32'hFF, 0, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ID, 32'hFFFF, 1, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_FLAGS, 32'hFF, 0, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_FLAGS, 32'hFFFF, 1,
              16'hFFFF);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_QDCOUNT, 32'h0, 0, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_QDCOUNT, 32'h0, 1, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ANCOUNT, 32'h0, 0, 16'h0);
      add_row(8'h01, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ANCOUNT, 32'h1, 1, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_NSCOUNT, 32'h0, 0, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_NSCOUNT, 32'h0, 1, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ARCOUNT, 32'h0, 0, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ARCOUNT, 32'h0, 1, 16'h0);
      add_row(8'hC0, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_POINTER, 32'hC0, 0, 16'h0);
      add_row(8'h0C, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_POINTER, 32'hC00C, 1,
              16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_TYPE, 32'h0, 0, 16'h0);
      add_row(8'h01, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_TYPE, 32'h1, 1, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_CLASS, 32'h0, 0, 16'h0);
      add_row(8'h01, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_CLASS, 32'h1, 1, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_TTL, 32'hFF, 0, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_TTL, 32'hFF, 0, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_TTL, 32'hFF, 0, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_TTL, 32'hFFFFFFFF, 1,
              16'h0);
      add_row(8'h00, 0, 0, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_RDLEN, 32'h0, 0, 16'h0);
      add_row(8'h00, 0, 0, dnsmp_pkg::SEC_ANSWER, dnsmp_pkg::FK_RDLEN, 32'h0, 1, 16'h0);
      add_row(8'h5A, 0, 1, dnsmp_pkg::SEC_TRAILING, dnsmp_pkg::FK_EXTRA, 32'h5A, 0, 16'h0);
      // restart from trailing: all-zero header, every count zero
      add_row(8'h00, 1, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ID, 32'h0, 0, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ID, 32'h0, 1, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_FLAGS, 32'h0, 0, 16'h0);
      add_row(8'h00, 0, 1, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_FLAGS, 32'h0, 1, 16'h0);
      for (i = 0; i < 8; i++)
         add_row(8'h00, 0, 0, dnsmp_pkg::SEC_HEADER, dnsmp_pkg::FK_ID, 32'h0, 0, 16'h0);
      add_row(8'hFF, 0, 1, dnsmp_pkg::SEC_TRAILING, dnsmp_pkg::FK_EXTRA, 32'hFF, 0, 16'h0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[j])
         send_byte(dir_rows[j].data, dir_rows[j].start, dir_rows[j].typed, dir_rows[j].tags);
      dir_len = bytes_sent;

      while (bytes_sent < dir_len + RANDOM_BYTES) begin
         build_message();
         calm = ($urandom_range(0, 5) == 0);
         foreach (msg_bytes[j])
            send_byte(msg_bytes[j][7:0], msg_bytes[j][8], 1'b0, '0);
      end
      calm = 1'b0;
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (expected_tags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d bytes (%0d directed) in %0d random messages, %0d malformed",
               bytes_sent, dir_len, msg_count, broken_count);
      $display("%0d result transactions checked, with a %0d-cycle receiver hold-off",
               results_seen, HOLD_CYCLES);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
